/* design/amffp_pkg.sv */
// ----------------------------------------------------------------------------
// amffp_pkg: shared definitions of the marker frame field parser
// Marker codes, result kinds, default sizes and character class helpers.
// ----------------------------------------------------------------------------
package amffp_pkg;

  localparam int unsigned DEF_BUFFER_LENGTH = 100;
  localparam int unsigned DEF_FIELD_DIGITS  = 8;

  localparam int unsigned FIELD_VALUE_W = 28;
  localparam int unsigned FIELD_KIND_W  = 2;

  // frame markers
  localparam logic [7:0] MARK_HEAD   = 8'h24;  // '$'
  localparam logic [7:0] MARK_FIRST  = 8'h26;  // '&'
  localparam logic [7:0] MARK_SECOND = 8'h5E;  // '^'
  localparam logic [7:0] MARK_STATUS = 8'h40;  // '@'
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  // result kinds
  localparam logic [FIELD_KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [FIELD_KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [FIELD_KIND_W-1:0] KIND_STATUS = 2'd2;

  // space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

endpackage

/* design/ascii_marker_frame_field_parser.sv */
// ----------------------------------------------------------------------------
// ascii_marker_frame_field_parser: marker framed field extraction
// Scans received frame bytes for '$', '&', '^' and '@' markers and emits
// the two decimal codes and the status byte that the markers enclose.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | data_byte_i, buffer_start_i
//  out     | source    | out_valid_o / out_stall_i| field_kind_o, field_value_o
//
//  A byte that completes no field leaves the parser idle; the next request
//  may follow in the following cycle.
//  A code request keeps the parser busy while it latches the enclosed
//  characters, passes each of them through the serial decimal converter
//  and hands the value to the output register.
//  A status request latches the status byte and hands it over.
//  in_stall_o is high while a field is converted or waits for the output
//  register; a full output register never stalls the request that makes a
//  field, but holds the finished field back and so stalls every request after it.
//  Reset clears the look-back window, the header flag, the byte position,
//  the converter state and the output valid flag.
//
module ascii_marker_frame_field_parser
  import amffp_pkg::*;
#(
  parameter int unsigned BUFFER_LENGTH = DEF_BUFFER_LENGTH,
  parameter int unsigned FIELD_DIGITS  = DEF_FIELD_DIGITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            buffer_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [FIELD_KIND_W-1:0]         field_kind_o,
  output logic signed [FIELD_VALUE_W-1:0] field_value_o
);

  localparam int unsigned WIN_DEPTH = FIELD_DIGITS + 1;
  localparam int unsigned POS_W     = $clog2(BUFFER_LENGTH + 1);
  localparam int unsigned CNT_W     = $clog2(FIELD_DIGITS + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // converter phases
  localparam logic [1:0] P_LEAD = 2'd0;  // skip blanks, take sign or first digit
  localparam logic [1:0] P_DIG  = 2'd1;  // accumulate digits
  localparam logic [1:0] P_STOP = 2'd2;  // ignore the rest

  logic [7:0]             win_q [WIN_DEPTH];
  logic [7:0]             win_d [WIN_DEPTH];
  logic                   hdr_q, hdr_d;
  logic [POS_W-1:0]       pos_q, pos_d;

  logic [1:0]             state_q, state_d;
  logic [1:0]             phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [7:0]             chr_q [FIELD_DIGITS];
  logic [7:0]             chr_d [FIELD_DIGITS];
  logic [FIELD_VALUE_W-1:0] acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [FIELD_KIND_W-1:0]  kind_q, kind_d;

  logic                   out_valid_q, out_valid_d;
  logic [FIELD_KIND_W-1:0]  out_kind_q, out_kind_d;
  logic [FIELD_VALUE_W-1:0] out_value_q, out_value_d;

  logic                   in_fire;
  logic                   out_free;

  // effective state seen by this request: a new buffer starts from reset
  logic [7:0]             ewin [WIN_DEPTH];
  logic                   ehdr;
  logic [POS_W-1:0]       epos;
  logic                   in_range, scan, hdr_n;
  logic                   hit_first, hit_second, hit_status;

  logic [7:0]             cur;
  logic [FIELD_VALUE_W-1:0] digit;
  logic [FIELD_VALUE_W-1:0] acc_x10;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      ewin[k] = buffer_start_i ? 8'h00 : win_q[k];
    end
    ehdr     = buffer_start_i ? 1'b0 : hdr_q;
    epos     = buffer_start_i ? '0 : pos_q;
    in_range = (epos < POS_W'(BUFFER_LENGTH));
    scan     = (epos <= POS_W'(BUFFER_LENGTH - 2));
    hdr_n    = ehdr || (scan && (data_byte_i == MARK_HEAD));

    hit_first  = scan && hdr_n && (data_byte_i == MARK_FIRST)
                 && (ewin[WIN_DEPTH-1] == MARK_HEAD);
    hit_second = scan && hdr_n && !hit_first && (data_byte_i == MARK_SECOND)
                 && (ewin[WIN_DEPTH-1] == MARK_FIRST);
    hit_status = scan && hdr_n && !hit_first && !hit_second
                 && (data_byte_i == MARK_STATUS) && (ewin[1] == MARK_SECOND);
  end

  // serial converter datapath: one character per cycle, oldest first
  assign cur     = chr_q[FIELD_DIGITS-1];
  assign digit   = FIELD_VALUE_W'(cur - CHAR_ZERO);
  assign acc_x10 = (acc_q << 3) + (acc_q << 1);

  always_comb begin
    win_d   = win_q;
    hdr_d   = hdr_q;
    pos_d   = pos_q;
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    chr_d   = chr_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    kind_d  = kind_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (buffer_start_i) begin
            win_d = ewin;
            hdr_d = 1'b0;
            pos_d = '0;
          end
          if (in_range) begin
            hdr_d    = hdr_n;
            win_d[0] = data_byte_i;
            for (int k = 1; k < WIN_DEPTH; k++) begin
              win_d[k] = ewin[k-1];
            end
            pos_d = epos + POS_W'(1);

            // latch the enclosed characters for the converter
            if (hit_first || hit_second) begin
              for (int k = 0; k < FIELD_DIGITS; k++) begin
                chr_d[k] = ewin[k];
              end
              kind_d  = hit_first ? KIND_FIRST : KIND_SECOND;
              acc_d   = '0;
              neg_d   = 1'b0;
              phase_d = P_LEAD;
              cnt_d   = CNT_W'(FIELD_DIGITS);
              state_d = S_CONV;
            end else if (hit_status) begin
              kind_d  = KIND_STATUS;
              acc_d   = FIELD_VALUE_W'(ewin[0]);
              neg_d   = 1'b0;
              state_d = S_DONE;
            end
          end
        end
      end

      S_CONV: begin
        case (phase_q)
          P_LEAD: begin
            if (is_blank(cur)) begin
              phase_d = P_LEAD;
            end else if (cur == CHAR_PLUS || cur == CHAR_MINUS) begin
              neg_d   = (cur == CHAR_MINUS);
              phase_d = P_DIG;
            end else if (is_digit(cur)) begin
              acc_d   = digit;
              phase_d = P_DIG;
            end else begin
              phase_d = P_STOP;
            end
          end
          P_DIG: begin
            if (is_digit(cur)) begin
              acc_d = acc_x10 + digit;
            end else begin
              phase_d = P_STOP;
            end
          end
          default: begin
            phase_d = P_STOP;
          end
        endcase
        // advance to the next character
        for (int k = FIELD_DIGITS - 1; k > 0; k--) begin
          chr_d[k] = chr_q[k-1];
        end
        chr_d[0] = 8'h00;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_value_d = neg_q ? (FIELD_VALUE_W'(0) - acc_q) : acc_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= 8'h00;
      end
      hdr_q       <= 1'b0;
      pos_q       <= '0;
      state_q     <= S_IDLE;
      phase_q     <= P_LEAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      hdr_q       <= hdr_d;
      pos_q       <= pos_d;
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chr_q       <= chr_d;
    acc_q       <= acc_d;
    neg_q       <= neg_d;
    kind_q      <= kind_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign field_kind_o  = out_kind_q;
  assign field_value_o = $signed(out_value_q);

endmodule

/* design/amffp_checker.sv */
// ----------------------------------------------------------------------------
// amffp_checker: port level checks of the marker frame field parser
// Watches the result channel and the value ranges of emitted fields.
// ----------------------------------------------------------------------------
module amffp_checker
  import amffp_pkg::*;
(
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [FIELD_KIND_W-1:0]         field_kind_o,
  input logic signed [FIELD_VALUE_W-1:0] field_value_o
);

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(field_kind_o) && $stable(field_value_o))
    else $error("stalled result changed");

  // a status result carries only a byte
  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == KIND_STATUS |-> field_value_o[FIELD_VALUE_W-1:8] == '0)
    else $error("status result wider than a byte");

  // a decoded code stays within the range of eight characters
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o != KIND_STATUS |->
      (field_value_o >= -28'sd9999999) && (field_value_o <= 28'sd99999999))
    else $error("code value out of range");

  // no request is taken while the input stalls
  a_busy_after_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_stall_o |-> 1'b0)
    else $error("request taken while stalled");

endmodule

bind ascii_marker_frame_field_parser amffp_checker u_amffp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .field_kind_o  (field_kind_o),
  .field_value_o (field_value_o)
);
